FILE: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked while reset is low
`define CHK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/lsq_pkg.sv
`default_nettype none
package lsq_pkg;

   localparam int FRAC_BITS = 24;
   localparam int N_W       = 13;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_CLAMP   = 2'd1,
      ST_SAT     = 2'd2,
      ST_INVALID = 2'd3
   } status_type;

   // one word travelling down the cell row
   typedef struct packed {
      logic                   valid;
      logic                   early;
      logic [15:0]            early_code;
      status_type             early_status;
      logic signed [N_W-1:0]  n;
      logic [63:0]            m;
      logic [FRAC_BITS-1:0]   frac;
   } stage_type;

   function automatic logic [5:0] top_bit64(input logic [63:0] v);
      logic [5:0] p;
      p = 6'd0;
      for (int i = 1; i < 64; i++) begin
         if (v[i]) p = 6'(i);
      end
      return p;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/lsq_front.sv
`default_nettype none
module lsq_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [63:0]       sample_bits,
   input  wire logic              format_sel,
   input  wire logic              scale_zero,
   output lsq_pkg::stage_type     out_stage
);
   localparam int N_W = lsq_pkg::N_W;

   logic                  neg;
   logic [10:0]           ef;
   logic [51:0]           mf;
   logic                  ef_max, ef_zero;
   logic [52:0]           mant;
   logic signed [N_W-1:0] expo, t_val, k_val, sh;
   logic [63:0]           xpart, onepart, a_val;
   logic                  early;
   logic [15:0]           ecode;
   lsq_pkg::status_type   est;

   // first stage registers
   logic                  v1_ff;
   logic                  early1_ff;
   logic [15:0]           ecode1_ff;
   lsq_pkg::status_type   est1_ff;
   logic signed [N_W-1:0] k1_ff;
   logic [63:0]           a1_ff;

   lsq_pkg::stage_type    s2_in, s2_ff;
   logic [5:0]            q;

   always_comb begin
      if (format_sel) begin
         neg     = sample_bits[63];
         ef      = sample_bits[62:52];
         mf      = sample_bits[51:0];
         ef_max  = (ef == 11'h7FF);
         ef_zero = (ef == 11'd0);
         mant    = ef_zero ? {1'b0, mf} : {1'b1, mf};
         expo    = ef_zero ? -13'sd1074 : $signed({2'b00, ef}) - 13'sd1075;
      end else begin
         neg     = sample_bits[31];
         ef      = {3'b000, sample_bits[30:23]};
         mf      = {29'd0, sample_bits[22:0]};
         ef_max  = (ef == 11'd255);
         ef_zero = (ef == 11'd0);
         mant    = ef_zero ? {30'd0, mf[22:0]} : {30'd1, mf[22:0]};
         expo    = ef_zero ? -13'sd149 : $signed({2'b00, ef}) - 13'sd150;
      end
      t_val = expo + $signed({7'd0, lsq_pkg::top_bit64({11'd0, mant})});
      k_val = (t_val > 0) ? t_val : '0;
      sh    = expo - k_val + 13'sd62;
      if (sh >= 0)
         xpart = {11'd0, mant} << sh[5:0];
      else if (-sh >= 13'sd64)
         xpart = '0;
      else
         xpart = {11'd0, mant} >> 6'(-sh);
      onepart = (k_val <= 13'sd62) ? (64'd1 << 6'(13'sd62 - k_val)) : '0;
      a_val   = neg ? onepart - xpart : onepart + xpart;

      early = 1'b1;
      ecode = 16'd0;
      est   = lsq_pkg::ST_OK;
      if (ef_max) begin
         if (mf != '0 || neg) est = lsq_pkg::ST_INVALID;
         else if (!scale_zero) begin
            ecode = 16'hFFFF;
            est   = lsq_pkg::ST_SAT;
         end
      end else if (mant == '0) begin
         est = lsq_pkg::ST_OK;
      end else if (neg && t_val >= 0) begin
         est = lsq_pkg::ST_INVALID;
      end else begin
         early = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff     <= in_valid;
         early1_ff <= early;
         ecode1_ff <= ecode;
         est1_ff   <= est;
         k1_ff     <= k_val;
         a1_ff     <= a_val;
      end
   end

   // normalize y to q1.63
   always_comb begin
      q                  = lsq_pkg::top_bit64(a1_ff);
      s2_in.valid        = v1_ff;
      s2_in.early        = early1_ff;
      s2_in.early_code   = ecode1_ff;
      s2_in.early_status = est1_ff;
      s2_in.n            = k1_ff - 13'sd62 + $signed({7'd0, q});
      s2_in.m            = a1_ff << (6'd63 - q);
      s2_in.frac         = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else if (en) begin
         s2_ff <= s2_in;
      end
   end

   assign out_stage = s2_ff;
endmodule
`default_nettype wire

FILE: rtl/lsq_cell.sv
`default_nettype none
module lsq_cell (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  lsq_pkg::stage_type in_stage,
   output lsq_pkg::stage_type out_stage
);
   lsq_pkg::stage_type sa_ff, sb_in, sb_ff;
   logic [63:0]        ll_ff, lh_ff, hh_ff;
   logic [127:0]       sq;

   // partial products of m*m
   always_ff @(posedge clock) begin
      if (reset) begin
         sa_ff.valid <= 1'b0;
      end else if (en) begin
         sa_ff <= in_stage;
         ll_ff <= in_stage.m[31:0] * in_stage.m[31:0];
         lh_ff <= in_stage.m[31:0] * in_stage.m[63:32];
         hh_ff <= in_stage.m[63:32] * in_stage.m[63:32];
      end
   end

   always_comb begin
      sq    = {hh_ff, 64'd0} + {31'd0, lh_ff, 33'd0} + {64'd0, ll_ff};
      sb_in = sa_ff;
      if (sq[127]) begin
         sb_in.m    = sq[127:64];
         sb_in.frac = {sa_ff.frac[lsq_pkg::FRAC_BITS-2:0], 1'b1};
      end else begin
         sb_in.m    = sq[126:63];
         sb_in.frac = {sa_ff.frac[lsq_pkg::FRAC_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_ff.valid <= 1'b0;
      end else if (en) begin
         sb_ff <= sb_in;
      end
   end

   assign out_stage = sb_ff;
endmodule
`default_nettype wire

FILE: rtl/lsq_back.sv
`default_nettype none
module lsq_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  lsq_pkg::stage_type in_stage,
   input  wire logic [31:0]   scale,
   output logic               advance,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [15:0]        log_code,
   output lsq_pkg::status_type status
);
   localparam int FB = lsq_pkg::FRAC_BITS;

   logic [63:0]         l_val;
   logic                pv_ff, early_ff, nneg_ff;
   logic [15:0]         ecode_ff;
   lsq_pkg::status_type est_ff;
   logic [63:0]         p0_ff, p1_ff;
   logic [95:0]         sum;
   logic                out_free;
   logic                rv_ff;
   logic [15:0]         code_ff, code_in;
   lsq_pkg::status_type st_ff, st_in;

   assign out_free = !rv_ff || rsp_ready;
   assign advance  = out_free || !pv_ff;
   assign l_val    = ({51'd0, in_stage.n} << FB) | {{(64-FB){1'b0}}, in_stage.frac};

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (advance) begin
         pv_ff    <= in_stage.valid;
         early_ff <= in_stage.early;
         ecode_ff <= in_stage.early_code;
         est_ff   <= in_stage.early_status;
         nneg_ff  <= in_stage.n < 0;
         p0_ff    <= l_val[31:0] * scale;
         p1_ff    <= l_val[63:32] * scale;
      end
   end

   always_comb begin
      sum = {32'd0, p0_ff} + {p1_ff, 32'd0};
      if (early_ff) begin
         code_in = ecode_ff;
         st_in   = est_ff;
      end else if (nneg_ff) begin
         code_in = 16'd0;
         st_in   = (scale == '0) ? lsq_pkg::ST_OK : lsq_pkg::ST_CLAMP;
      end else if (|sum[95:FB+32]) begin
         code_in = 16'hFFFF;
         st_in   = lsq_pkg::ST_SAT;
      end else begin
         code_in = sum[FB+31:FB+16];
         st_in   = lsq_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (out_free) begin
         rv_ff   <= pv_ff;
         code_ff <= code_in;
         st_ff   <= st_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign log_code  = code_ff;
   assign status    = st_ff;
endmodule
`default_nettype wire

FILE: rtl/log2_sample_quantizer_core.sv
// log2 sample quantizer
// req channel: one IEEE sample per word in req_tdata (single precision in the
// low 32 bits, double in all 64, chosen by the format register).
// rsp channel: floor(log2(x+1)*scale) as a 16-bit code plus a 2-bit status
// (ok, clamped to zero, saturated, invalid).
// csr port: register 0 at address 0 is the format bit, register 1 at
// address 4 the unsigned q16.16 scale; write only while the block is idle.
// the pipeline has two decode stages, a row of 24 squaring cells of two
// stages each (one log2 bit per cell), a scale multiply stage and the
// output register.
// throughput is one word per cycle while req_tready is high.
// when rsp_tready is low the output register holds its word and the whole
// pipeline keeps moving until the scale multiply stage holds a word too,
// then req_tready drops and every stage holds.
// reset empties the pipeline and sets format 0 and scale 1.0.
`default_nettype none
module log2_sample_quantizer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [63:0] sample_bits
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [15:0] log_code, [17:16] status, zero pad
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam int FB = lsq_pkg::FRAC_BITS;

   logic                format_ff;
   logic [31:0]         scale_ff;
   logic                advance;
   logic [15:0]         log_code;
   lsq_pkg::status_type status;
   lsq_pkg::stage_type  chain [0:FB];

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? scale_ff : {31'd0, format_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= 1'b0;
         scale_ff  <= 32'd65536;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2]) scale_ff  <= csr_pwdata;
         else              format_ff <= csr_pwdata[0];
      end
   end

   assign req_tready = advance;

   lsq_front u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (advance),
      .in_valid    (req_tvalid),
      .sample_bits (req_tdata),
      .format_sel  (format_ff),
      .scale_zero  (scale_ff == '0),
      .out_stage   (chain[0])
   );

   for (genvar g = 0; g < FB; g++) begin : g_cell
      lsq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (advance),
         .in_stage  (chain[g]),
         .out_stage (chain[g+1])
      );
   end

   lsq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (chain[FB]),
      .scale     (scale_ff),
      .advance   (advance),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .log_code  (log_code),
      .status    (status)
   );

   assign rsp_tdata = {6'd0, status, log_code};
endmodule
`default_nettype wire

FILE: rtl/lsq_checker.sv
`default_nettype none
`include "assert_macros.svh"
module lsq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);
   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp word dropped while stalled")
   `CHK_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_tvalid, "rsp valid right after reset")
   `CHK_ASSERT(a_invalid_zero, clock, reset, rsp_tvalid && rsp_tdata[17:16] == lsq_pkg::ST_INVALID |-> rsp_tdata[15:0] == 16'd0, "invalid status with nonzero code")
   `CHK_ASSERT(a_clamp_zero, clock, reset, rsp_tvalid && rsp_tdata[17:16] == lsq_pkg::ST_CLAMP |-> rsp_tdata[15:0] == 16'd0, "clamped status with nonzero code")
   `CHK_ASSERT(a_sat_full, clock, reset, rsp_tvalid && rsp_tdata[17:16] == lsq_pkg::ST_SAT |-> rsp_tdata[15:0] == 16'hFFFF, "saturated status without full code")
endmodule

bind log2_sample_quantizer_core lsq_checker u_lsq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
